// File: sv/riff_wav_stream_parser_unit_macros.svh
// Assertion macros for the RIFF WAV stream parser.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef RIFF_WAV_STREAM_PARSER_UNIT_MACROS_SVH
`define RIFF_WAV_STREAM_PARSER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWSP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RWSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rwsp_pkg.sv
// Shared types and constants of the RIFF WAV stream parser.
// No dependencies; the top level, the parser and the result queue import this package.
package rwsp_pkg;

    // Chunk and file identifiers, first byte in bits 7:0.
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;
    localparam logic [31:0] ID_SMPL = 32'h6C70_6D73;

    // Result kinds.
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_FMT  = 2'd1;
    localparam logic [1:0] KIND_LOOP = 2'd2;
    localparam logic [1:0] KIND_END  = 2'd3;

    // End status codes.
    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_BAD_RIFF  = 3'd1;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
    localparam logic [2:0] ST_BAD_WAVE  = 3'd3;
    localparam logic [2:0] ST_NOT_PCM   = 3'd4;
    localparam logic [2:0] ST_BAD_FMT   = 3'd5;
    localparam logic [2:0] ST_NO_FMT    = 3'd6;
    localparam logic [2:0] ST_OVERRUN   = 3'd7;

    // Format codes.
    localparam logic [2:0] FMT_NONE     = 3'd0;
    localparam logic [2:0] FMT_MONO8    = 3'd1;
    localparam logic [2:0] FMT_MONO16   = 3'd2;
    localparam logic [2:0] FMT_STEREO8  = 3'd3;
    localparam logic [2:0] FMT_STEREO16 = 3'd4;

    // Chunk kinds.
    localparam logic [1:0] CK_OTHER = 2'd0;
    localparam logic [1:0] CK_FMT   = 2'd1;
    localparam logic [1:0] CK_DATA  = 2'd2;
    localparam logic [1:0] CK_SMPL  = 2'd3;

    // Default depth of the result queue; must be at least four.
    localparam int unsigned RWSP_RES_DEPTH = 8;

    // One queued result. The value carries the data word, the sample rate or
    // the loop word, and the code carries the byte count, format or status,
    // depending on the kind.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic [2:0]  code;
        logic        last;
    } t_result;

    // What the parser reports to the top level each cycle.
    typedef struct packed {
        logic [1:0] push_cnt;
        logic       stopped;
    } t_parse_stat;

    function automatic t_result mk_result(input logic [1:0] kind, input logic [31:0] value,
                                          input logic [2:0] code);
        t_result r;
        r.kind  = kind;
        r.value = value;
        r.code  = code;
        r.last  = 1'b0;
        return r;
    endfunction

endpackage

// File: sv/rwsp_in_if.sv
// Input channel of the RIFF WAV stream parser: one file word per transfer.
// No dependencies.
interface rwsp_in_if;
    logic        valid;
    logic        ready;
    logic        start_req;
    logic [31:0] word;

    modport source (output valid, output start_req, output word, input ready);
    modport sink   (input valid, input start_req, input word, output ready);
endinterface

// File: sv/rwsp_out_if.sv
// Result channel of the RIFF WAV stream parser: one result per transfer.
// No dependencies.
interface rwsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic [2:0]  format_code;
    logic [31:0] sample_rate;
    logic [31:0] loop_value;
    logic [2:0]  status;
    logic        last_of_run;

    modport source (output valid, output kind, output data_word, output byte_count,
                    output format_code, output sample_rate, output loop_value,
                    output status, output last_of_run, input ready);
    modport sink   (input valid, input kind, input data_word, input byte_count,
                    input format_code, input sample_rate, input loop_value,
                    input status, input last_of_run, output ready);
endinterface

// File: sv/riff_wav_stream_parser_unit.sv
// RIFF WAV stream parser, top level. A result can transfer once the word that
// causes it has passed the input register and been written into the result queue.
// Throughput: one word per cycle while the result queue has four free entries;
// a word yields at most two results, drained from the queue one per cycle while the receiver is ready.
// Reset (synchronous, active low) stops the parser and empties the queue.
// Depends on rwsp_pkg, rwsp_in_if, rwsp_out_if, rwsp_parser, rwsp_result_fifo.
`include "riff_wav_stream_parser_unit_macros.svh"

module riff_wav_stream_parser_unit #(
    parameter int unsigned RES_DEPTH = rwsp_pkg::RWSP_RES_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rwsp_in_if.sink   i_in,
    rwsp_out_if.source o_out
);
    import rwsp_pkg::*;

    localparam int unsigned CNT_W = $clog2(RES_DEPTH + 1);
    // Room for the word in the input register and the next one.
    localparam int unsigned ACCEPT_LIMIT = RES_DEPTH - 4;

    logic         in_ready;
    logic         in_xfer;
    logic         r_in_valid;
    logic         r_in_start;
    logic [31:0]  r_in_word;
    t_result      res0;
    t_result      res1;
    t_parse_stat  stat;
    t_result      head;
    logic [CNT_W-1:0] fifo_count;
    logic         pop;
    t_result      last_pushed;

    assign in_ready   = (fifo_count <= CNT_W'(ACCEPT_LIMIT));
    assign in_xfer    = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_start <= i_in.start_req;
            r_in_word  <= i_in.word;
        end
    end

    rwsp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_start (r_in_start),
        .i_word  (r_in_word),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_stat  (stat)
    );

    rwsp_result_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (stat.push_cnt),
        .i_push0    (res0),
        .i_push1    (res1),
        .i_pop      (pop),
        .o_head     (head),
        .o_count    (fifo_count)
    );

    assign pop = o_out.valid && o_out.ready;

    // Fields that do not belong to the result kind read as zero.
    assign o_out.valid       = (fifo_count != '0);
    assign o_out.kind        = head.kind;
    assign o_out.data_word   = (head.kind == KIND_DATA) ? head.value : 32'd0;
    assign o_out.byte_count  = (head.kind == KIND_DATA) ? head.code : 3'd0;
    assign o_out.format_code = (head.kind == KIND_FMT) ? head.code : 3'd0;
    assign o_out.sample_rate = (head.kind == KIND_FMT) ? head.value : 32'd0;
    assign o_out.loop_value  = (head.kind == KIND_LOOP) ? head.value : 32'd0;
    assign o_out.status      = (head.kind == KIND_END) ? head.code : 3'd0;
    assign o_out.last_of_run = head.last;

    assign last_pushed = (stat.push_cnt == 2'd2) ? res1 : res0;

    `RWSP_ASSERT_SAME(a_queue_bound, 1'b1, fifo_count <= CNT_W'(RES_DEPTH),
                      "result queue holds more entries than its depth")
    `RWSP_ASSERT_SAME(a_stopped_quiet, r_in_valid && !r_in_start && stat.stopped,
                      stat.push_cnt == 2'd0, "stopped parser emitted a result")
    `RWSP_ASSERT_SAME(a_pair_marks, stat.push_cnt == 2'd2, !res0.last && res1.last,
                      "end of run marked on the wrong result of a pair")
    `RWSP_ASSERT_NEXT(a_end_stops, stat.push_cnt != 2'd0 && last_pushed.kind == KIND_END,
                      stat.stopped, "parser kept running after an end result")

endmodule

// File: sv/rwsp_result_fifo.sv
// Result queue of the RIFF WAV stream parser: takes up to two results per
// cycle and hands out one per cycle when popped. Depends on rwsp_pkg.
module rwsp_result_fifo #(
    parameter int unsigned DEPTH = rwsp_pkg::RWSP_RES_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_push_cnt,
    input  rwsp_pkg::t_result           i_push0,
    input  rwsp_pkg::t_result           i_push1,
    input  logic                        i_pop,
    output rwsp_pkg::t_result           o_head,
    output logic [$clog2(DEPTH+1)-1:0]  o_count
);
    import rwsp_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   wr1;
    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;
    logic [CNT_W-1:0]   n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

    assign wr1 = ptr_inc(r_wr);

    always_comb begin
        unique case (i_push_cnt)
            2'd1:    n_wr = wr1;
            2'd2:    n_wr = ptr_inc(wr1);
            default: n_wr = r_wr;
        endcase
        n_rd    = i_pop ? ptr_inc(r_rd) : r_rd;
        n_count = r_count + CNT_W'(i_push_cnt) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_push0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr1] <= i_push1;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

// File: sv/rwsp_parser.sv
// Parsing state machine of the RIFF WAV stream parser: walks the file one
// registered word per cycle while i_valid is high and emits up to two results. Depends on rwsp_pkg.
module rwsp_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_start,
    input  logic [31:0]           i_word,
    output rwsp_pkg::t_result     o_res0,
    output rwsp_pkg::t_result     o_res1,
    output rwsp_pkg::t_parse_stat o_stat
);
    import rwsp_pkg::*;

    typedef enum logic [5:0] {
        PH_STOP = 6'b000001,
        PH_SIZE = 6'b000010,
        PH_WAVE = 6'b000100,
        PH_CID  = 6'b001000,
        PH_CSZ  = 6'b010000,
        PH_BODY = 6'b100000
    } t_phase;

    t_phase       r_phase,     n_phase;
    logic [29:0]  r_words_left, n_words_left;
    logic [1:0]   r_chunk_kind, n_chunk_kind;
    logic [31:0]  r_chunk_bytes, n_chunk_bytes;
    logic [29:0]  r_body_index, n_body_index;
    logic         r_fmt_ok,    n_fmt_ok;
    logic         r_chan_one,  n_chan_one;
    logic         r_chan_two,  n_chan_two;
    logic [31:0]  r_rate,      n_rate;

    logic         prim_v;
    t_result      prim;
    logic         end_v;
    logic [2:0]   end_status;
    logic [29:0]  wl_dec;
    logic [30:0]  size_words;
    logic [31:0]  rem;
    logic [15:0]  bits;
    logic [2:0]   fmt_code;
    logic         abort;

    assign wl_dec     = r_words_left - 30'd1;
    assign size_words = {1'b0, i_word[31:2]} + 31'(|i_word[1:0]);
    // Bytes of the chunk body from the current word on.
    assign rem        = r_chunk_bytes - {r_body_index, 2'b00};
    assign bits       = i_word[31:16];

    always_comb begin
        if (r_chan_one && bits == 16'd8) begin
            fmt_code = FMT_MONO8;
        end else if (r_chan_one && bits == 16'd16) begin
            fmt_code = FMT_MONO16;
        end else if (r_chan_two && bits == 16'd8) begin
            fmt_code = FMT_STEREO8;
        end else if (r_chan_two && bits == 16'd16) begin
            fmt_code = FMT_STEREO16;
        end else begin
            fmt_code = FMT_NONE;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_words_left  = r_words_left;
        n_chunk_kind  = r_chunk_kind;
        n_chunk_bytes = r_chunk_bytes;
        n_body_index  = r_body_index;
        n_fmt_ok      = r_fmt_ok;
        n_chan_one    = r_chan_one;
        n_chan_two    = r_chan_two;
        n_rate        = r_rate;
        prim_v        = 1'b0;
        prim          = mk_result(KIND_DATA, 32'd0, 3'd0);
        end_v         = 1'b0;
        end_status    = ST_DONE;
        abort         = 1'b0;

        if (i_valid) begin
            if (i_start) begin
                n_words_left  = '0;
                n_chunk_kind  = CK_OTHER;
                n_chunk_bytes = '0;
                n_body_index  = '0;
                n_fmt_ok      = 1'b0;
                n_chan_one    = 1'b0;
                n_chan_two    = 1'b0;
                n_rate        = '0;
                if (i_word != ID_RIFF) begin
                    end_v      = 1'b1;
                    end_status = ST_BAD_RIFF;
                end else begin
                    n_phase = PH_SIZE;
                end
            end else begin
                unique case (r_phase)
                    PH_SIZE: begin
                        if (i_word < 32'd4) begin
                            end_v      = 1'b1;
                            end_status = ST_BAD_SIZE;
                        end else begin
                            n_words_left = 30'((i_word - 32'd1) >> 2);
                            n_phase      = PH_WAVE;
                        end
                    end
                    PH_WAVE: begin
                        if (i_word != ID_WAVE) begin
                            end_v      = 1'b1;
                            end_status = ST_BAD_WAVE;
                        end else if (r_words_left < 30'd2) begin
                            end_v = 1'b1;
                        end else begin
                            n_phase = PH_CID;
                        end
                    end
                    PH_CID: begin
                        priority if (i_word == ID_FMT) begin
                            n_chunk_kind = CK_FMT;
                        end else if (i_word == ID_DATA) begin
                            n_chunk_kind = CK_DATA;
                        end else if (i_word == ID_SMPL) begin
                            n_chunk_kind = CK_SMPL;
                        end else begin
                            n_chunk_kind = CK_OTHER;
                        end
                        n_words_left = wl_dec;
                        n_phase      = PH_CSZ;
                    end
                    PH_CSZ: begin
                        n_chunk_bytes = i_word;
                        n_words_left  = wl_dec;
                        n_body_index  = '0;
                        // Overrun is checked before the other header errors.
                        if (size_words > {1'b0, wl_dec}) begin
                            end_v      = 1'b1;
                            end_status = ST_OVERRUN;
                        end else if (r_chunk_kind == CK_DATA && !r_fmt_ok) begin
                            end_v      = 1'b1;
                            end_status = ST_NO_FMT;
                        end else if ((r_chunk_kind == CK_FMT && i_word < 32'd16) ||
                                     (r_chunk_kind == CK_SMPL && i_word < 32'd32)) begin
                            end_v      = 1'b1;
                            end_status = ST_OVERRUN;
                        end else if (i_word == 32'd0) begin
                            if (wl_dec < 30'd2) begin
                                end_v = 1'b1;
                            end else begin
                                n_phase = PH_CID;
                            end
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        n_words_left = wl_dec;
                        unique case (r_chunk_kind)
                            CK_FMT: begin
                                if (r_body_index == 30'd0) begin
                                    if (i_word[15:0] != 16'd1) begin
                                        end_v      = 1'b1;
                                        end_status = ST_NOT_PCM;
                                        abort      = 1'b1;
                                    end else begin
                                        n_chan_one = (bits == 16'd1);
                                        n_chan_two = (bits == 16'd2);
                                    end
                                end else if (r_body_index == 30'd1) begin
                                    n_rate = i_word;
                                end else if (r_body_index == 30'd3) begin
                                    if (fmt_code == FMT_NONE) begin
                                        end_v      = 1'b1;
                                        end_status = ST_BAD_FMT;
                                        abort      = 1'b1;
                                    end else begin
                                        n_fmt_ok = 1'b1;
                                        prim_v   = 1'b1;
                                        prim     = mk_result(KIND_FMT, r_rate, fmt_code);
                                    end
                                end
                            end
                            CK_DATA: begin
                                prim_v = 1'b1;
                                prim   = mk_result(KIND_DATA, i_word,
                                                   (rem > 32'd4) ? 3'd4 : rem[2:0]);
                            end
                            CK_SMPL: begin
                                if (r_body_index == 30'd7) begin
                                    prim_v = 1'b1;
                                    prim   = mk_result(KIND_LOOP, i_word, 3'd0);
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (!abort) begin
                            n_body_index = r_body_index + 30'd1;
                            // The chunk ends on the word that holds its last bytes.
                            if (rem <= 32'd4) begin
                                if (wl_dec < 30'd2) begin
                                    end_v = 1'b1;
                                end else begin
                                    n_phase = PH_CID;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (end_v) begin
            n_phase = PH_STOP;
        end
    end

    always_comb begin
        o_res0 = mk_result(KIND_END, 32'd0, end_status);
        o_res1 = mk_result(KIND_END, 32'd0, end_status);
        if (prim_v) begin
            o_res0 = prim;
        end
        unique case ({prim_v, end_v})
            2'b11: begin
                o_stat.push_cnt = 2'd2;
                o_res1.last     = 1'b1;
            end
            2'b10, 2'b01: begin
                o_stat.push_cnt = 2'd1;
                o_res0.last     = 1'b1;
            end
            default: begin
                o_stat.push_cnt = 2'd0;
            end
        endcase
        o_stat.stopped = (r_phase == PH_STOP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_STOP;
            r_fmt_ok <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_fmt_ok <= n_fmt_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_words_left  <= n_words_left;
        r_chunk_kind  <= n_chunk_kind;
        r_chunk_bytes <= n_chunk_bytes;
        r_body_index  <= n_body_index;
        r_chan_one    <= n_chan_one;
        r_chan_two    <= n_chan_two;
        r_rate        <= n_rate;
    end

endmodule
